// ----- design/dprc_pkg.sv -----
// shared types, constants and helpers for the debug packet receive check
// used by dprc_accum, dprc_verdict and debug_packet_receive_check
`default_nettype none

package dprc_pkg;

	localparam int unsigned MAX_CHUNK = 2046;
	localparam int unsigned CNT_W     = 11;

	localparam logic [7:0] CH_START = 8'h24;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_BAD   = 8'hFF;

	localparam logic [CNT_W-1:0] CNT_MAX    = CNT_W'(MAX_CHUNK);
	localparam logic [CNT_W-1:0] CNT_MIN    = CNT_W'(4);
	localparam logic [CNT_W-1:0] CNT_SEQMIN = CNT_W'(7);

	localparam logic [2:0] OFS_PLAIN = 3'd1;
	localparam logic [2:0] OFS_SEQ   = 3'd4;

	localparam int unsigned OUT_BITS = 33;
	localparam int unsigned OUT_W    = ((OUT_BITS + 7) / 8) * 8;

	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic [7:0]       sum;
		logic [7:0]       rec0;
		logic [7:0]       rec1;
		logic [7:0]       rec2;
		logic [7:0]       head0;
		logic [7:0]       head1;
		logic [7:0]       head2;
		logic [7:0]       head3;
		logic             ovf;
	} chunk_state_t;

	typedef struct packed {
		logic             too_long;
		logic [CNT_W-1:0] payload_length;
		logic [2:0]       payload_offset;
		logic [7:0]       seq_second;
		logic [7:0]       seq_first;
		logic             seq_present;
		logic             ack_good;
	} verdict_t;

	// hex digit value, all ones for anything else
	function automatic logic [7:0] digit_value(input logic [7:0] c);
		logic [7:0] v;
		v = CH_BAD;
		if (c >= 8'h61 && c <= 8'h66) v = c - 8'h61 + 8'd10;
		else if (c >= 8'h30 && c <= 8'h39) v = c - 8'h30;
		else if (c >= 8'h41 && c <= 8'h46) v = c - 8'h41 + 8'd10;
		return v;
	endfunction

endpackage

`default_nettype wire

// ----- design/dprc_accum.sv -----
// per-chunk state: length count, running sum, last three bytes, head bytes
// depends on dprc_pkg
`default_nettype none

module dprc_accum (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  en,
	input  wire logic [7:0]            byte_in,
	input  wire logic                  last_in,
	output dprc_pkg::chunk_state_t     nxt
);
	import dprc_pkg::*;

	chunk_state_t cur_q;

	always_comb begin
		nxt = cur_q;
		if (cur_q.count >= CNT_MAX) begin
			nxt.ovf = 1'b1;
		end else begin
			unique case (cur_q.count)
				CNT_W'(0): nxt.head0 = byte_in;
				CNT_W'(1): nxt.head1 = byte_in;
				CNT_W'(2): nxt.head2 = byte_in;
				CNT_W'(3): nxt.head3 = byte_in;
				default: ;
			endcase
			if (cur_q.count != '0) nxt.sum = cur_q.sum + byte_in;
			nxt.rec0  = cur_q.rec1;
			nxt.rec1  = cur_q.rec2;
			nxt.rec2  = byte_in;
			nxt.count = cur_q.count + CNT_W'(1);
		end
	end

	// all state clears at reset; head bytes are kept across a chunk end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q.count <= '0;
			cur_q.sum   <= '0;
			cur_q.rec0  <= '0;
			cur_q.rec1  <= '0;
			cur_q.rec2  <= '0;
			cur_q.head0 <= '0;
			cur_q.head1 <= '0;
			cur_q.head2 <= '0;
			cur_q.head3 <= '0;
			cur_q.ovf   <= 1'b0;
		end else if (en) begin
			cur_q.head0 <= nxt.head0;
			cur_q.head1 <= nxt.head1;
			cur_q.head2 <= nxt.head2;
			cur_q.head3 <= nxt.head3;
			if (last_in) begin
				cur_q.count <= '0;
				cur_q.sum   <= '0;
				cur_q.rec0  <= '0;
				cur_q.rec1  <= '0;
				cur_q.rec2  <= '0;
				cur_q.ovf   <= 1'b0;
			end else begin
				cur_q.count <= nxt.count;
				cur_q.sum   <= nxt.sum;
				cur_q.rec0  <= nxt.rec0;
				cur_q.rec1  <= nxt.rec1;
				cur_q.rec2  <= nxt.rec2;
				cur_q.ovf   <= nxt.ovf;
			end
		end
	end

endmodule

`default_nettype wire

// ----- design/dprc_verdict.sv -----
// framing and checksum verdict from the updated chunk state
// depends on dprc_pkg
`default_nettype none

module dprc_verdict (
	input  wire dprc_pkg::chunk_state_t st,
	output dprc_pkg::verdict_t          vd
);
	import dprc_pkg::*;

	logic [7:0] body;
	logic [7:0] want;
	logic [7:0] hi_v;
	logic [7:0] lo_v;
	logic       good;
	logic       seq;

	always_comb begin
		body = st.sum - st.rec0 - st.rec1 - st.rec2;
		hi_v = digit_value(st.rec1);
		lo_v = digit_value(st.rec2);
		want = {hi_v[3:0], 4'b0000} + lo_v;
		good = !st.ovf && (st.count >= CNT_MIN) && (st.head0 == CH_START)
			&& (st.rec0 == CH_HASH) && (body == want);
		seq  = good && (st.count >= CNT_SEQMIN) && (st.head3 == CH_COLON);

		vd.ack_good       = good;
		vd.seq_present    = seq;
		vd.seq_first      = seq ? st.head1 : 8'h00;
		vd.seq_second     = seq ? st.head2 : 8'h00;
		vd.payload_offset = seq ? OFS_SEQ : OFS_PLAIN;
		if (seq)       vd.payload_length = st.count - CNT_SEQMIN;
		else if (good) vd.payload_length = st.count - CNT_MIN;
		else           vd.payload_length = '0;
		vd.too_long       = st.ovf;
	end

endmodule

`default_nettype wire

// ----- design/debug_packet_receive_check.sv -----
// a byte is registered in the input register on accept and processed from there; the verdict
// of a chunk's last byte is registered in the output register when that byte is processed
// throughput: one byte per cycle, set by the combinational sum and shift update;
// a last byte waits in the input register only while an earlier verdict is not taken
// reset: arst_n clears count, sum, recent and head bytes, overflow flag and both valid flags
// depends on dprc_pkg, dprc_accum, dprc_verdict
`default_nettype none

module debug_packet_receive_check (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       s_axis_tvalid,
	output logic                            s_axis_tready,
	input  wire logic [7:0]                 s_axis_tdata,  // rx_byte
	input  wire logic                       s_axis_tlast,  // end_of_read
	output logic                            m_axis_tvalid,
	input  wire logic                       m_axis_tready,
	// ack_good, seq_present, seq_first, seq_second, payload_offset, payload_length,
	// too_long, zero pad
	output logic [dprc_pkg::OUT_W-1:0]      m_axis_tdata
);
	import dprc_pkg::*;

	logic         valid_s1;
	logic [7:0]   byte_s1;
	logic         last_s1;
	logic         fire_s1;
	logic         out_valid_q;
	verdict_t     out_q;
	chunk_state_t nxt;
	verdict_t     vd;

	// a last byte needs a free result slot, other bytes move freely
	assign fire_s1       = valid_s1 && (!last_s1 || !out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	dprc_accum u_accum (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (fire_s1),
		.byte_in (byte_s1),
		.last_in (last_s1),
		.nxt     (nxt)
	);

	dprc_verdict u_verdict (
		.st (nxt),
		.vd (vd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && last_s1) out_q <= vd;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_W'(out_q);

endmodule

`default_nettype wire
